// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/core/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// Types, constants and helpers of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipru_pkg;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT    = 4096;

    localparam int SCALE_W  = 7;
    localparam int WIDTH_W  = 13;
    localparam int HEIGHT_W = 13;
    localparam int ROW_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       image_end;
    } out_t;

    // Pad count (4 - 3*w*s mod 4) mod 4 depends only on the low two bits of w and s.
    function automatic logic [1:0] pad_count(input logic [1:0] w_lo, input logic [1:0] s_lo);
        logic [3:0] prod;
        logic [1:0] bytes;
        prod  = {2'b00, w_lo} * {2'b00, s_lo};
        bytes = prod[1:0] + {prod[0], 1'b0};
        return 2'd0 - bytes;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipru_line_buf.sv
// ----------------------------------------------------------------------------
// ipru_line_buf
// One-row pixel store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipru_line_buf #(
    parameter int DEPTH = ipru_pkg::DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [ipru_pkg::PIX_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [ipru_pkg::PIX_W-1:0] rd_data
);

    logic [ipru_pkg::PIX_W-1:0] mem [DEPTH];
    logic [ipru_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/integer_pixel_replication_upscaler_core.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_core
// Nearest-neighbor integer upscaler for 24-bit pixels with a one-row buffer.
// ----------------------------------------------------------------------------
// A load request writes one pixel into the line buffer at the next column.
// Once a full source row is held, loads are dropped and each tick request
// gives one output pixel: every source pixel repeats scale times across and
// the row repeats scale times down. The last pixel of an output row carries
// the pad byte count, and the last pixel of the image sets image_end.
// Ticks before a row is complete give nothing.
// The input channel takes one request per clock while in_stall is low. A tick
// that emits shows its pixel on the output in the cycle after acceptance;
// the buffer read is the output register.
// When the receiver stalls a pending pixel, the input stalls until the pixel
// is taken; the output holds steady meanwhile.
// Reset clears all counters and sets scale, width and height to one. The
// buffer contents are not cleared and need no clearing pass.
// Configuration writes are taken every cycle (cfg_ready is always high) and
// must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module integer_pixel_replication_upscaler_core #(
    parameter int MAX_WIDTH = ipru_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire ipru_pkg::in_t                   in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output ipru_pkg::out_t                       out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > ipru_pkg::WIDTH_W) ? WW : ipru_pkg::WIDTH_W;
    localparam int SW = ipru_pkg::SCALE_W;
    localparam int HW = ipru_pkg::HEIGHT_W;
    localparam int RW = ipru_pkg::ROW_W;

    logic [SW-1:0] scale_reg;
    logic [ipru_pkg::WIDTH_W-1:0] src_width_reg;
    logic [HW-1:0] src_height_reg;

    logic [AW-1:0] load_column_reg, load_column_next;
    logic          row_full_reg, row_full_next;
    logic [AW-1:0] emit_column_reg, emit_column_next;
    logic [SW-1:0] across_repeat_reg, across_repeat_next;
    logic [SW-1:0] down_repeat_reg, down_repeat_next;
    logic [RW-1:0] source_row_reg, source_row_next;

    logic       out_valid_reg, out_valid_next;
    logic       row_end_reg;
    logic [1:0] pad_bytes_reg;
    logic       image_end_reg;

    logic [SW-1:0] s_eff;
    logic [CW-1:0] w_ext;
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic in_fire;
    logic load_fire;
    logic emit_fire;
    logic last_across;
    logic last_col;
    logic last_down;
    logic last_row;
    logic last_load;
    logic row_end_c;
    logic image_end_c;

    logic [ipru_pkg::PIX_W-1:0] rd_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= SW'(1);
            src_width_reg  <= ipru_pkg::WIDTH_W'(1);
            src_height_reg <= HW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipru_pkg::CFG_SCALE:  scale_reg      <= cfg_data[SW-1:0];
                ipru_pkg::CFG_WIDTH:  src_width_reg  <= cfg_data;
                ipru_pkg::CFG_HEIGHT: src_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_eff = (scale_reg == '0) ? SW'(1) : scale_reg;
    assign w_ext = CW'(src_width_reg);

    always_comb
    begin
        if (w_ext == '0)
        begin
            w_eff = CW'(1);
        end
        else if (w_ext > CW'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
    end

    always_comb
    begin
        if (src_height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (src_height_reg > HW'(ipru_pkg::MAX_HEIGHT))
        begin
            h_eff = HW'(ipru_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = src_height_reg;
        end
    end

    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign load_fire = in_fire && (in_data.req_type == ipru_pkg::REQ_LOAD) && !row_full_reg;
    assign emit_fire = in_fire && (in_data.req_type == ipru_pkg::REQ_TICK) && row_full_reg;

    assign last_load   = (CW'(load_column_reg) + CW'(1)) >= w_eff;
    assign last_across = ({1'b0, across_repeat_reg} + (SW + 1)'(1)) >= {1'b0, s_eff};
    assign last_col    = (CW'(emit_column_reg) + CW'(1)) >= w_eff;
    assign last_down   = ({1'b0, down_repeat_reg} + (SW + 1)'(1)) >= {1'b0, s_eff};
    assign last_row    = (HW'(source_row_reg) + HW'(1)) >= h_eff;
    assign row_end_c   = last_across && last_col;
    assign image_end_c = row_end_c && last_down && last_row;

    always_comb
    begin
        load_column_next   = load_column_reg;
        row_full_next      = row_full_reg;
        emit_column_next   = emit_column_reg;
        across_repeat_next = across_repeat_reg;
        down_repeat_next   = down_repeat_reg;
        source_row_next    = source_row_reg;

        if (load_fire)
        begin
            if (last_load)
            begin
                load_column_next = '0;
                row_full_next    = 1'b1;
            end
            else
            begin
                load_column_next = load_column_reg + AW'(1);
            end
        end

        if (emit_fire)
        begin
            if (!last_across)
            begin
                across_repeat_next = across_repeat_reg + SW'(1);
            end
            else
            begin
                across_repeat_next = '0;
                if (!last_col)
                begin
                    emit_column_next = emit_column_reg + AW'(1);
                end
                else
                begin
                    emit_column_next = '0;
                    if (!last_down)
                    begin
                        down_repeat_next = down_repeat_reg + SW'(1);
                    end
                    else
                    begin
                        down_repeat_next = '0;
                        row_full_next    = 1'b0;
                        if (last_row)
                        begin
                            source_row_next = '0;
                        end
                        else
                        begin
                            source_row_next = source_row_reg + RW'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_column_reg   <= '0;
            row_full_reg      <= 1'b0;
            emit_column_reg   <= '0;
            across_repeat_reg <= '0;
            down_repeat_reg   <= '0;
            source_row_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            load_column_reg   <= load_column_next;
            row_full_reg      <= row_full_next;
            emit_column_reg   <= emit_column_next;
            across_repeat_reg <= across_repeat_next;
            down_repeat_reg   <= down_repeat_next;
            source_row_reg    <= source_row_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            row_end_reg   <= row_end_c;
            pad_bytes_reg <= row_end_c ? ipru_pkg::pad_count(w_eff[1:0], s_eff[1:0]) : 2'd0;
            image_end_reg <= image_end_c;
        end
    end

    // Writes happen only while no row is held and reads only while one is,
    // so the two ports never touch the same entry in the same cycle.
    ipru_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (load_column_reg),
        .wr_data ({in_data.red_in, in_data.green_in, in_data.blue_in}),
        .rd_en   (emit_fire),
        .rd_addr (emit_column_reg),
        .rd_data (rd_pix)
    );

    assign out_valid          = out_valid_reg;
    assign out_data.red_out   = rd_pix[23:16];
    assign out_data.green_out = rd_pix[15:8];
    assign out_data.blue_out  = rd_pix[7:0];
    assign out_data.row_end   = row_end_reg;
    assign out_data.pad_bytes = pad_bytes_reg;
    assign out_data.image_end = image_end_reg;

    `ASSERT_NEVER(a_no_write_while_full, clk, rst_n, load_fire && row_full_reg, "line buffer written while a row is held")
    `ASSERT_PROP(a_full_clears_on_emit, clk, rst_n, $fell(row_full_reg) |-> $past(emit_fire), "row released without an emitted pixel")
    `ASSERT_PROP(a_valid_from_emit, clk, rst_n, $rose(out_valid_reg) |-> $past(emit_fire), "output raised without an accepted tick")
    `ASSERT_NEVER(a_image_end_row_end, clk, rst_n, out_valid_reg && image_end_reg && !row_end_reg, "image end flagged off a row end")
    `ASSERT_NEVER(a_pad_only_row_end, clk, rst_n, out_valid_reg && (pad_bytes_reg != 2'd0) && !row_end_reg, "pad bytes off a row end")

endmodule

`default_nettype wire

// File: tb/integer_pixel_replication_upscaler_core_tb.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_core_tb
// Self-checking testbench for the nearest-neighbor integer upscaler core.
// ----------------------------------------------------------------------------
// Load and tick requests are sent over the input channel while the output
// channel is stalled at random. A predictor keeps its own copy of the line
// buffer, the counters and the registers, and queues the pixel that each
// accepted tick must produce. Every output pixel is compared with the oldest
// queued one. Directed tests cover reset defaults, zero and clamped register
// values, register changes in the middle of a row or an image, and an
// oversized width cut short during a load. Random images with noise requests
// follow, under several idling phases on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_replication_upscaler_core_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int AW = $clog2(ipru_pkg::DEF_MAX_WIDTH);

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    ipru_pkg::in_t                   in_data = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    ipru_pkg::out_t                  out_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ipru_pkg::CFG_IDX_W-1:0]  cfg_index = ipru_pkg::CFG_SCALE;
    logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    integer_pixel_replication_upscaler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state.
    logic [ipru_pkg::PIX_W-1:0]    line_buf [ipru_pkg::DEF_MAX_WIDTH];
    logic [ipru_pkg::WIDTH_W-1:0]  fill_col = '0;
    logic                          row_held = 1'b0;
    logic [ipru_pkg::ROW_W-1:0]    emit_col = '0;
    logic [ipru_pkg::SCALE_W-1:0]  rep_across = '0;
    logic [ipru_pkg::SCALE_W-1:0]  rep_down = '0;
    logic [ipru_pkg::ROW_W-1:0]    src_row = '0;
    logic [ipru_pkg::SCALE_W-1:0]  reg_scale = ipru_pkg::SCALE_W'(1);
    logic [ipru_pkg::WIDTH_W-1:0]  reg_width = ipru_pkg::WIDTH_W'(1);
    logic [ipru_pkg::HEIGHT_W-1:0] reg_height = ipru_pkg::HEIGHT_W'(1);
    int                            filled_cols = 0;

    ipru_pkg::out_t expected_pixels [$];

    int idle_in_pct = 0;
    int stall_out_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int pixels_checked = 0;
    int requests_sent = 0;
    int images_done = 0;
    int cfg_writes = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_scale();
        return (reg_scale == 0) ? 1 : int'(reg_scale);
    endfunction

    function automatic int eff_width(input logic [ipru_pkg::WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        if (int'(w) > ipru_pkg::DEF_MAX_WIDTH)
            return ipru_pkg::DEF_MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic int eff_height();
        if (reg_height == 0)
            return 1;
        if (int'(reg_height) > ipru_pkg::MAX_HEIGHT)
            return ipru_pkg::MAX_HEIGHT;
        return int'(reg_height);
    endfunction

    function automatic void predict_upscaled_pixel(input ipru_pkg::in_t req);
        int             s;
        int             w;
        int             h;
        logic           last_across;
        logic           last_col;
        logic           last_down;
        logic           last_row;
        ipru_pkg::out_t pix;
        s = eff_scale();
        w = eff_width(reg_width);
        h = eff_height();
        if (req.req_type == ipru_pkg::REQ_LOAD)
        begin
            if (row_held)
                return;
            if (int'(fill_col) < ipru_pkg::DEF_MAX_WIDTH)
            begin
                line_buf[fill_col[AW-1:0]] = {req.red_in, req.green_in, req.blue_in};
                if (int'(fill_col) + 1 > filled_cols)
                    filled_cols = int'(fill_col) + 1;
            end
            if (int'(fill_col) + 1 >= w)
            begin
                fill_col = '0;
                row_held = 1'b1;
            end
            else
                fill_col = fill_col + 1'b1;
            return;
        end
        if (!row_held)
            return;
        last_across = (int'(rep_across) + 1 >= s);
        last_col    = (int'(emit_col) + 1 >= w);
        last_down   = (int'(rep_down) + 1 >= s);
        last_row    = (int'(src_row) + 1 >= h);
        {pix.red_out, pix.green_out, pix.blue_out} = line_buf[emit_col];
        pix.row_end   = last_across && last_col;
        pix.image_end = pix.row_end && last_down && last_row;
        pix.pad_bytes = pix.row_end ? 2'((4 - ((3 * w * s) & 3)) & 3) : 2'd0;
        expected_pixels.push_back(pix);
        if (pix.image_end)
            images_done++;
        if (!last_across)
            rep_across = rep_across + 1'b1;
        else
        begin
            rep_across = '0;
            if (!last_col)
                emit_col = emit_col + 1'b1;
            else
            begin
                emit_col = '0;
                if (!last_down)
                    rep_down = rep_down + 1'b1;
                else
                begin
                    rep_down = '0;
                    row_held = 1'b0;
                    src_row = last_row ? '0 : src_row + 1'b1;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input ipru_pkg::out_t want,
                                   input ipru_pkg::out_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0d] %s: expected rgb=%02h%02h%02h row_end=%0d pad=%0d image_end=%0d",
                     cycles, what, want.red_out, want.green_out, want.blue_out, want.row_end,
                     want.pad_bytes, want.image_end);
            $display("[%0d] %s: got      rgb=%02h%02h%02h row_end=%0d pad=%0d image_end=%0d",
                     cycles, what, got.red_out, got.green_out, got.blue_out, got.row_end,
                     got.pad_bytes, got.image_end);
        end
    endtask

    always @(posedge clk)
    begin : check_output
        ipru_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("pixel with no request pending", '0, out_data);
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out
                    || out_data.blue_out !== want.blue_out || out_data.row_end !== want.row_end
                    || out_data.pad_bytes !== want.pad_bytes
                    || out_data.image_end !== want.image_end)
                    report_mismatch("pixel mismatch", want, out_data);
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_out_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding.", cycles,
                     expected_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(input logic kind, input logic [ipru_pkg::PIX_W-1:0] rgb);
        ipru_pkg::in_t req;
        req.req_type = kind;
        {req.red_in, req.green_in, req.blue_in} = rgb;
        while ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        predict_upscaled_pixel(req);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A width that grows past the columns ever loaded while a row is held
    // would read buffer entries that were never written, so it is capped.
    task automatic cfg_write(input logic [ipru_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipru_pkg::CFG_DATA_W-1:0] value);
        logic [ipru_pkg::CFG_DATA_W-1:0] data;
        data = value;
        if (idx == ipru_pkg::CFG_WIDTH && row_held && eff_width(value) > filled_cols)
            data = ipru_pkg::CFG_DATA_W'(filled_cols);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        case (idx)
            ipru_pkg::CFG_SCALE:  reg_scale  = data[ipru_pkg::SCALE_W-1:0];
            ipru_pkg::CFG_WIDTH:  reg_width  = data[ipru_pkg::WIDTH_W-1:0];
            ipru_pkg::CFG_HEIGHT: reg_height = data[ipru_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int s, input int w, input int h);
        cfg_write(ipru_pkg::CFG_SCALE, ipru_pkg::CFG_DATA_W'(s));
        cfg_write(ipru_pkg::CFG_WIDTH, ipru_pkg::CFG_DATA_W'(w));
        cfg_write(ipru_pkg::CFG_HEIGHT, ipru_pkg::CFG_DATA_W'(h));
        cfg_valid <= 1'b0;
    endtask

    task automatic set_register(input logic [ipru_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_write(idx, ipru_pkg::CFG_DATA_W'(value));
        cfg_valid <= 1'b0;
    endtask

    task automatic load_row();
        while (!row_held)
            send_req(ipru_pkg::REQ_LOAD, ipru_pkg::PIX_W'($urandom));
    endtask

    task automatic drain_row();
        while (row_held)
            send_req(ipru_pkg::REQ_TICK, ipru_pkg::PIX_W'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_req(ipru_pkg::REQ_TICK, 24'h000000);
        send_req(ipru_pkg::REQ_LOAD, 24'hFFFFFF);
        send_req(ipru_pkg::REQ_LOAD, 24'h000000);
        send_req(ipru_pkg::REQ_TICK, 24'hFFFFFF);
        send_req(ipru_pkg::REQ_TICK, 24'h000000);
        send_req(ipru_pkg::REQ_LOAD, 24'h000000);
        send_req(ipru_pkg::REQ_TICK, 24'h000000);
        wait_idle();
    endtask

    task automatic test_zero_registers();
        set_geometry(0, 0, 0);
        send_req(ipru_pkg::REQ_LOAD, 24'hAA55AA);
        send_req(ipru_pkg::REQ_TICK, 24'h55AA55);
        wait_idle();
    endtask

    task automatic test_scale_shrink_mid_row();
        set_geometry(127, 2, 1);
        send_req(ipru_pkg::REQ_LOAD, 24'h00FF00);
        send_req(ipru_pkg::REQ_LOAD, 24'hFF00FF);
        repeat (3) send_req(ipru_pkg::REQ_TICK, 24'h000000);
        wait_idle();
        set_register(ipru_pkg::CFG_SCALE, 2);
        drain_row();
        wait_idle();
    endtask

    task automatic test_height_shrink_mid_image();
        set_geometry(1, 1, 8191);
        repeat (2)
        begin
            load_row();
            drain_row();
        end
        wait_idle();
        set_register(ipru_pkg::CFG_HEIGHT, 1);
        load_row();
        drain_row();
        wait_idle();
    endtask

    task automatic test_oversized_width_shrink();
        set_geometry(1, 8191, 1);
        repeat (16) send_req(ipru_pkg::REQ_LOAD, ipru_pkg::PIX_W'($urandom));
        repeat (2) send_req(ipru_pkg::REQ_TICK, 24'h000000);
        wait_idle();
        set_register(ipru_pkg::CFG_WIDTH, 5);
        load_row();
        drain_row();
        wait_idle();
    endtask

    task automatic random_geometry();
        int s;
        int w;
        int h;
        int r;
        r = $urandom_range(99);
        if (r < 70)
            s = $urandom_range(1, 4);
        else if (r < 95)
            s = $urandom_range(5, 8);
        else
            s = $urandom_range(9, 12);
        if (s > 4)
        begin
            w = $urandom_range(1, 3);
            h = 1;
        end
        else
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            h = $urandom_range(1, 3);
        end
        if ($urandom_range(99) < 3)
            s = 0;
        if ($urandom_range(99) < 3)
            w = 0;
        if ($urandom_range(99) < 3)
            h = 0;
        set_geometry(s, w, h);
    endtask

    task automatic test_random_images(input int in_pct, input int out_pct, input int budget);
        int   counted;
        logic kind;
        logic noise;
        idle_in_pct   = in_pct;
        stall_out_pct = out_pct;
        counted = 0;
        while (counted < budget)
        begin
            if (!row_held && fill_col == 0 && src_row == 0 && $urandom_range(99) < 30)
            begin
                wait_idle();
                random_geometry();
            end
            else if ($urandom_range(199) == 0)
            begin
                wait_idle();
                case ($urandom_range(2))
                    0: set_register(ipru_pkg::CFG_SCALE, $urandom_range(1, 4));
                    1: set_register(ipru_pkg::CFG_WIDTH, $urandom_range(1, 6));
                    default: set_register(ipru_pkg::CFG_HEIGHT, $urandom_range(1, 3));
                endcase
            end
            noise = ($urandom_range(99) < 8);
            kind = row_held ? ipru_pkg::REQ_TICK : ipru_pkg::REQ_LOAD;
            if (noise)
                kind = ~kind;
            else
                counted++;
            send_req(kind, ipru_pkg::PIX_W'($urandom));
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_registers();
        test_scale_shrink_mid_row();
        test_height_shrink_mid_image();
        idle_in_pct   = 6;
        stall_out_pct = 6;
        test_oversized_width_shrink();
        test_random_images(0, 0, 440);
        test_random_images(59, 0, 440);
        test_random_images(0, 59, 440);
        test_random_images(6, 6, 440);
        wait_idle();
        $display("Sent %0d requests in four idling phases; checked %0d pixels in %0d images.",
                 requests_sent, pixels_checked, images_done);
        $display("Made %0d register writes, including zero, clamped and mid-image values.",
                 cfg_writes);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: integer_pixel_replication_upscaler_core.f
+incdir+rtl/core
rtl/core/ipru_pkg.sv
rtl/core/ipru_line_buf.sv
rtl/core/integer_pixel_replication_upscaler_core.sv
tb/integer_pixel_replication_upscaler_core_tb.sv
